FILE: sv/rhmw_pkg.sv
// Package for the right-hand maze walker: action, status, heading and
// register index codes, reset values and heading step helpers.
// No dependencies.
`default_nettype none

package rhmw_pkg;

    // action codes (input tuser)
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_STEPPED  = 3'd1;
    localparam logic [2:0] ST_GOAL     = 3'd2;
    localparam logic [2:0] ST_LIMIT    = 3'd3;
    localparam logic [2:0] ST_BOUNDS   = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // headings
    localparam logic [1:0] HD_NORTH = 2'd0;
    localparam logic [1:0] HD_EAST  = 2'd1;
    localparam logic [1:0] HD_SOUTH = 2'd2;
    localparam logic [1:0] HD_WEST  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MAZE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_MAZE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_GOAL_X      = 3'd2;
    localparam logic [2:0] CFG_GOAL_Y      = 3'd3;
    localparam logic [2:0] CFG_STEP_LIMIT  = 3'd4;

    // configuration reset values
    localparam logic [4:0] RST_MAZE_WIDTH  = 5'd13;
    localparam logic [4:0] RST_MAZE_HEIGHT = 5'd13;
    localparam logic [3:0] RST_GOAL_X      = 4'd0;
    localparam logic [3:0] RST_GOAL_Y      = 4'd2;
    localparam logic [7:0] RST_STEP_LIMIT  = 8'd100;

    localparam logic [7:0] STEP_SAT = 8'd255;

    // one input request, as unpacked from the stream
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] start_heading;
        logic       is_wall;
        logic [3:0] pos_y;
        logic [3:0] pos_x;
    } t_req;

    // one result
    typedef struct packed {
        logic [7:0] step_count;
        logic [2:0] status;
        logic [1:0] heading;
        logic [3:0] cur_y;
        logic [3:0] cur_x;
    } t_rsp;

    // x offset of a heading, two's complement in 6 bits
    function automatic logic [5:0] dir_dx(input logic [1:0] h);
        logic [5:0] d;
        unique case (h)
            HD_EAST: d = 6'h01;
            HD_WEST: d = 6'h3F;
            default: d = 6'h00;
        endcase
        return d;
    endfunction

    // y offset of a heading, north is toward row zero
    function automatic logic [5:0] dir_dy(input logic [1:0] h);
        logic [5:0] d;
        unique case (h)
            HD_NORTH: d = 6'h3F;
            HD_SOUTH: d = 6'h01;
            default:  d = 6'h00;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/right_hand_maze_walker.sv
// Right-hand maze walker: a request passes the input register, then one
// combinational pass into the result register.
// Throughput one request per cycle while the result stream is not stalled;
// the pace is set by the single update of walker state and wall grid per cycle.
// Synchronous active-low reset clears walker state, handshake state and
// config to defaults; the wall grid is not reset and must be written first.
// Depends on rhmw_pkg.
`default_nettype none

module right_hand_maze_walker
    import rhmw_pkg::*;
#(
    parameter int GRID_SIDE = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // pos_x[3:0], pos_y[7:4], is_wall[8],
                                        // start_heading[10:9], zero[15:11]
    input  wire  [1:0]  s_axis_tuser,   // action[1:0]

    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // cur_x[3:0], cur_y[7:4], heading[9:8],
                                        // status[12:10], step_count[20:13],
                                        // zero[23:21]

    // config write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_wdata
);

    // Coordinates are 4 bits, so cells past 15 can never be reached.
    localparam int CELLS_SIDE = (GRID_SIDE < 16) ? GRID_SIDE : 16;
    localparam int IDX_W      = $clog2(CELLS_SIDE);
    localparam logic [5:0] SIDE6 = 6'(CELLS_SIDE);

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [4:0] r_maze_width;
    logic [4:0] r_maze_height;
    logic [3:0] r_goal_x;
    logic [3:0] r_goal_y;
    logic [7:0] r_step_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_width  <= RST_MAZE_WIDTH;
            r_maze_height <= RST_MAZE_HEIGHT;
            r_goal_x      <= RST_GOAL_X;
            r_goal_y      <= RST_GOAL_Y;
            r_step_limit  <= RST_STEP_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAZE_WIDTH:  r_maze_width  <= i_cfg_wdata[4:0];
                CFG_MAZE_HEIGHT: r_maze_height <= i_cfg_wdata[4:0];
                CFG_GOAL_X:      r_goal_x      <= i_cfg_wdata[3:0];
                CFG_GOAL_Y:      r_goal_y      <= i_cfg_wdata[3:0];
                CFG_STEP_LIMIT:  r_step_limit  <= i_cfg_wdata;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic w_proc;

    // process the held request when the result slot is free or draining
    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action        <= s_axis_tuser;
            r_in.pos_x         <= s_axis_tdata[3:0];
            r_in.pos_y         <= s_axis_tdata[7:4];
            r_in.is_wall       <= s_axis_tdata[8];
            r_in.start_heading <= s_axis_tdata[10:9];
        end
    end

    // ---------------------------------------------------------------
    // Walker state and wall grid (grid bit 1 = wall, no reset)
    // ---------------------------------------------------------------
    logic [3:0] r_x, n_x;
    logic [3:0] r_y, n_y;
    logic [1:0] r_head, n_head;
    logic [7:0] r_steps, n_steps;
    logic       r_done, n_done;
    t_rsp       n_out;

    logic [CELLS_SIDE-1:0] r_wall [CELLS_SIDE];

    // neighbor cells to the right and straight ahead
    logic [1:0] w_right_h, w_left_h;
    logic [5:0] w_rx, w_ry, w_fx, w_fy;
    logic       w_right_open, w_fwd_open;
    logic       w_wr_en;
    logic [7:0] w_steps_inc;

    assign w_right_h = r_head + 2'd1;
    assign w_left_h  = r_head - 2'd1;
    assign w_rx = {2'b00, r_x} + dir_dx(w_right_h);
    assign w_ry = {2'b00, r_y} + dir_dy(w_right_h);
    assign w_fx = {2'b00, r_x} + dir_dx(r_head);
    assign w_fy = {2'b00, r_y} + dir_dy(r_head);

    // off-grid neighbors (negative wraps to bit 5 set) read as walls
    assign w_right_open = !w_rx[5] && !w_ry[5] && (w_rx < SIDE6) && (w_ry < SIDE6)
                          && !r_wall[w_ry[IDX_W-1:0]][w_rx[IDX_W-1:0]];
    assign w_fwd_open   = !w_fx[5] && !w_fy[5] && (w_fx < SIDE6) && (w_fy < SIDE6)
                          && !r_wall[w_fy[IDX_W-1:0]][w_fx[IDX_W-1:0]];

    assign w_steps_inc = (r_steps < STEP_SAT) ? r_steps + 8'd1 : r_steps;

    // writes outside the stored grid are ignored
    assign w_wr_en = w_proc && (r_in.action == ACT_WRITE)
                     && ({2'b00, r_in.pos_x} < SIDE6) && ({2'b00, r_in.pos_y} < SIDE6);

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_head  = r_head;
        n_steps = r_steps;
        n_done  = r_done;
        n_out.status = ST_ACCEPTED;
        unique case (r_in.action)
            ACT_START: begin
                n_x     = r_in.pos_x;
                n_y     = r_in.pos_y;
                n_head  = r_in.start_heading;
                n_steps = 8'd0;
                n_done  = 1'b0;
            end
            ACT_STEP: begin
                if (r_done) begin
                    n_out.status = ST_DONE;
                end else begin
                    n_steps = w_steps_inc;
                    if (w_steps_inc > r_step_limit) begin
                        n_done       = 1'b1;
                        n_out.status = ST_LIMIT;
                    end else if (({1'b0, r_x} >= r_maze_width)
                                 || ({1'b0, r_y} >= r_maze_height)) begin
                        n_done       = 1'b1;
                        n_out.status = ST_BOUNDS;
                    end else begin
                        // right-hand rule: right, else ahead, else turn left
                        if (w_right_open) begin
                            n_head = w_right_h;
                            n_x    = w_rx[3:0];
                            n_y    = w_ry[3:0];
                        end else if (w_fwd_open) begin
                            n_x = w_fx[3:0];
                            n_y = w_fy[3:0];
                        end else begin
                            n_head = w_left_h;
                        end
                        if ((n_x == r_goal_x) && (n_y == r_goal_y)) begin
                            n_done       = 1'b1;
                            n_out.status = ST_GOAL;
                        end else begin
                            n_out.status = ST_STEPPED;
                        end
                    end
                end
            end
            default: ;  // write and the unused action leave the walker alone
        endcase
        n_out.cur_x      = n_x;
        n_out.cur_y      = n_y;
        n_out.heading    = n_head;
        n_out.step_count = n_steps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= 4'd0;
            r_y     <= 4'd0;
            r_head  <= HD_NORTH;
            r_steps <= 8'd0;
            r_done  <= 1'b0;
        end else if (w_proc) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_head  <= n_head;
            r_steps <= n_steps;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_wall[r_in.pos_y[IDX_W-1:0]][r_in.pos_x[IDX_W-1:0]] <= r_in.is_wall;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.step_count, r_out.status, r_out.heading,
                            r_out.cur_y, r_out.cur_x};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // a finished walk stays finished until a start request is processed
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(w_proc && (r_in.action == ACT_START))) |=> r_done)
        else $error("walk finished flag dropped without a start");

    // walker state only moves when a request is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_proc |=> ($stable(r_x) && $stable(r_y) && $stable(r_head)
                     && $stable(r_steps)))
        else $error("walker state changed without a request");

    // a step request advances the count by at most one
    a_step_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (r_in.action == ACT_STEP)) |=>
            ((r_steps == $past(r_steps)) || (r_steps == $past(r_steps) + 8'd1)))
        else $error("step count jumped");

    // no result is overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_proc)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
